// ===== rtl/core/suffix_automaton_build_and_match_unit_macros.svh =====
// assertion macros for the suffix automaton unit
// used by rtl files that carry concurrent checks; no other dependencies
`ifndef SUFFIX_AUTOMATON_BUILD_AND_MATCH_UNIT_MACROS_SVH
`define SUFFIX_AUTOMATON_BUILD_AND_MATCH_UNIT_MACROS_SVH

// same-cycle implication under synchronous reset
`define SAM_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("sam check failed");

// next-cycle implication under synchronous reset
`define SAM_ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("sam check failed");

`endif

// ===== rtl/core/sam_pkg.sv =====
// package for the suffix automaton unit: constants, codes and sequencer states
// no dependencies
`default_nettype none

package sam_pkg;

   localparam int SYM_W            = 5;
   localparam int LEN_OUT_W        = 12;
   localparam int DEF_MAX_STATES   = 4096;
   localparam int DEF_ALPHABET     = 26;

   localparam logic REQ_EXTEND     = 1'b0;
   localparam logic REQ_MATCH      = 1'b1;

   localparam logic STATUS_DONE    = 1'b0;
   localparam logic STATUS_REFUSED = 1'b1;

   typedef enum logic [4:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_EXT_LEN,
      ST_EXT_NEW,
      ST_ADD_RD,
      ST_ADD_CHK,
      ST_PLEN_RD,
      ST_QLEN_RD,
      ST_CMP,
      ST_CL_LINK,
      ST_CUR_LINK,
      ST_Q_LINK,
      ST_COPY,
      ST_COPY_END,
      ST_RED_RD,
      ST_RED_CHK,
      ST_M_RD,
      ST_M_CHK,
      ST_M_LEN
   } sam_state_type;

endpackage

`default_nettype wire

// ===== rtl/core/suffix_automaton_build_and_match_unit.sv =====
// top level of the suffix automaton unit: sequencer and shared datapath
// depends on sam_pkg, sam_ram and the assertion macro header
//
// usage: raise start with req_type, req_symbol and req_start_query while busy
// is low; the beat is taken at that edge and busy rises until the item is done,
// but stays low for a refused extend. every accepted beat gives exactly one
// result: rsp_strobe is high for one cycle with rsp_match_length, rsp_best_length
// and rsp_status. the receiver cannot stall, so results are never held back.
// an extend reads the length of last, writes the new state's length and then
// walks suffix links, with a transition and a link read per link; a compare reads
// both lengths, and a clone writes three links, copies the ROW_N entries of row q
// into the clone and redirects the transitions that still lead to q. a match reads
// a transition and a link, and a length for each suffix link followed on a mismatch.
// a refused extend answers in the cycle after it is taken.
// after reset the transition table is swept to zero, one entry a cycle, over
// all 2**TA_W entries (131072 at default); busy stays high through the sweep.
`default_nettype none
`include "suffix_automaton_build_and_match_unit_macros.svh"

module suffix_automaton_build_and_match_unit #(
   parameter int MAX_STATES = sam_pkg::DEF_MAX_STATES,
   parameter int ALPHABET   = sam_pkg::DEF_ALPHABET
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           start,
   output logic                                busy,
   input  wire logic                           req_type,
   input  wire logic [sam_pkg::SYM_W-1:0]      req_symbol,
   input  wire logic                           req_start_query,
   output logic                                rsp_strobe,
   output logic [sam_pkg::LEN_OUT_W-1:0]       rsp_match_length,
   output logic [sam_pkg::LEN_OUT_W-1:0]       rsp_best_length,
   output logic                                rsp_status
);
   import sam_pkg::*;

   localparam int ST_W  = $clog2(MAX_STATES);
   localparam int TA_W  = ST_W + SYM_W;
   localparam int ROW_N = (ALPHABET < (2 ** SYM_W)) ? ALPHABET : (2 ** SYM_W);
   localparam logic [ST_W-1:0]  ROOT      = ST_W'(1);
   localparam logic [ST_W-1:0]  NONE      = '0;
   localparam logic [ST_W-1:0]  CNT_LIMIT = ST_W'(MAX_STATES - 3);
   localparam logic [SYM_W-1:0] ROW_LAST  = SYM_W'(ROW_N - 1);

   sam_state_type    state_ff, state_in;
   logic [ST_W-1:0]  last_ff, last_in;
   logic [ST_W-1:0]  count_ff, count_in;
   logic [ST_W-1:0]  walk_ff, walk_in;
   logic [ST_W-1:0]  wlen_ff, wlen_in;
   logic [ST_W-1:0]  best_ff, best_in;
   logic [ST_W-1:0]  p_ff, p_in;
   logic [ST_W-1:0]  cur_ff, cur_in;
   logic [ST_W-1:0]  q_ff, q_in;
   logic [ST_W-1:0]  cl_ff, cl_in;
   logic [ST_W-1:0]  plen_ff, plen_in;
   logic [SYM_W-1:0] sym_ff, sym_in;
   logic [TA_W-1:0]  clr_ff, clr_in;
   logic [SYM_W-1:0] ci_ff, ci_in;
   logic [SYM_W-1:0] cwi_ff, cwi_in;
   logic             cw_ff, cw_in;
   logic             rsp_strobe_ff, rsp_strobe_in;
   logic [ST_W-1:0]  rsp_len_ff, rsp_len_in;
   logic [ST_W-1:0]  rsp_best_ff, rsp_best_in;
   logic             rsp_status_ff, rsp_status_in;

   logic             t_we;
   logic [TA_W-1:0]  t_waddr, t_raddr;
   logic [ST_W-1:0]  t_wdata, t_rd;
   logic             l_we;
   logic [ST_W-1:0]  l_waddr, l_raddr, l_wdata, l_rd;
   logic             k_we;
   logic [ST_W-1:0]  k_waddr, k_raddr, k_wdata, k_rd;

   logic [ST_W-1:0]  nw_len, nw_best, m_len;
   logic             known;

   sam_ram #(.WIDTH(ST_W), .DEPTH(2 ** TA_W)) u_trans (
      .clock(clock), .we(t_we), .waddr(t_waddr), .wdata(t_wdata),
      .raddr(t_raddr), .rdata(t_rd)
   );

   sam_ram #(.WIDTH(ST_W), .DEPTH(MAX_STATES)) u_len (
      .clock(clock), .we(l_we), .waddr(l_waddr), .wdata(l_wdata),
      .raddr(l_raddr), .rdata(l_rd)
   );

   sam_ram #(.WIDTH(ST_W), .DEPTH(MAX_STATES)) u_link (
      .clock(clock), .we(k_we), .waddr(k_waddr), .wdata(k_wdata),
      .raddr(k_raddr), .rdata(k_rd)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_CLEAR;
         last_ff       <= ROOT;
         count_ff      <= ROOT;
         walk_ff       <= ROOT;
         wlen_ff       <= '0;
         best_ff       <= '0;
         clr_ff        <= '0;
         cw_ff         <= 1'b0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         last_ff       <= last_in;
         count_ff      <= count_in;
         walk_ff       <= walk_in;
         wlen_ff       <= wlen_in;
         best_ff       <= best_in;
         clr_ff        <= clr_in;
         cw_ff         <= cw_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      p_ff          <= p_in;
      cur_ff        <= cur_in;
      q_ff          <= q_in;
      cl_ff         <= cl_in;
      plen_ff       <= plen_in;
      sym_ff        <= sym_in;
      ci_ff         <= ci_in;
      cwi_ff        <= cwi_in;
      rsp_len_ff    <= rsp_len_in;
      rsp_best_ff   <= rsp_best_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign nw_len  = req_start_query ? '0 : wlen_ff;
   assign nw_best = req_start_query ? '0 : best_ff;
   assign known   = 32'(sym_ff) < 32'(ALPHABET);
   assign m_len   = wlen_ff + ST_W'(1);

   always_comb begin
      state_in      = state_ff;
      last_in       = last_ff;
      count_in      = count_ff;
      walk_in       = walk_ff;
      wlen_in       = wlen_ff;
      best_in       = best_ff;
      p_in          = p_ff;
      cur_in        = cur_ff;
      q_in          = q_ff;
      cl_in         = cl_ff;
      plen_in       = plen_ff;
      sym_in        = sym_ff;
      clr_in        = clr_ff;
      ci_in         = ci_ff;
      cwi_in        = cwi_ff;
      cw_in         = cw_ff;
      rsp_strobe_in = 1'b0;
      rsp_len_in    = rsp_len_ff;
      rsp_best_in   = rsp_best_ff;
      rsp_status_in = rsp_status_ff;
      t_we = 1'b0; t_waddr = '0; t_wdata = '0; t_raddr = '0;
      l_we = 1'b0; l_waddr = '0; l_wdata = '0; l_raddr = '0;
      k_we = 1'b0; k_waddr = '0; k_wdata = '0; k_raddr = '0;

      unique case (state_ff)
         ST_CLEAR: begin
            t_we    = 1'b1;
            t_waddr = clr_ff;
            l_we    = 1'b1;
            l_waddr = ROOT;
            k_we    = 1'b1;
            k_waddr = ROOT;
            k_wdata = NONE;
            clr_in  = clr_ff + TA_W'(1);
            if (clr_ff == '1) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (start) begin
               sym_in  = req_symbol;
               wlen_in = nw_len;
               best_in = nw_best;
               if (req_start_query) begin
                  walk_in = ROOT;
               end
               if (req_type == REQ_MATCH) begin
                  state_in = ST_M_RD;
               end else if (32'(req_symbol) < 32'(ALPHABET) && count_ff <= CNT_LIMIT) begin
                  state_in = ST_EXT_LEN;
               end else begin
                  rsp_strobe_in = 1'b1;
                  rsp_len_in    = nw_len;
                  rsp_best_in   = nw_best;
                  rsp_status_in = STATUS_REFUSED;
               end
            end
         end
         ST_EXT_LEN: begin
            l_raddr  = last_ff;
            p_in     = last_ff;
            cur_in   = count_ff + ST_W'(1);
            count_in = count_ff + ST_W'(1);
            state_in = ST_EXT_NEW;
         end
         ST_EXT_NEW: begin
            l_we     = 1'b1;
            l_waddr  = cur_ff;
            l_wdata  = l_rd + ST_W'(1);
            state_in = ST_ADD_RD;
         end
         ST_ADD_RD: begin
            t_raddr  = {p_ff, sym_ff};
            k_raddr  = p_ff;
            state_in = ST_ADD_CHK;
         end
         ST_ADD_CHK: begin
            if (t_rd == NONE) begin
               t_we    = 1'b1;
               t_waddr = {p_ff, sym_ff};
               t_wdata = cur_ff;
               p_in    = k_rd;
               if (k_rd == NONE) begin
                  // fell off the root: new state links to root
                  k_we          = 1'b1;
                  k_waddr       = cur_ff;
                  k_wdata       = ROOT;
                  last_in       = cur_ff;
                  state_in      = ST_IDLE;
                  rsp_strobe_in = 1'b1;
                  rsp_len_in    = wlen_ff;
                  rsp_best_in   = best_ff;
                  rsp_status_in = STATUS_DONE;
               end else begin
                  state_in = ST_ADD_RD;
               end
            end else begin
               q_in     = t_rd;
               last_in  = cur_ff;
               state_in = ST_PLEN_RD;
            end
         end
         ST_PLEN_RD: begin
            l_raddr  = p_ff;
            state_in = ST_QLEN_RD;
         end
         ST_QLEN_RD: begin
            plen_in  = l_rd;
            l_raddr  = q_ff;
            state_in = ST_CMP;
         end
         ST_CMP: begin
            if (l_rd == plen_ff + ST_W'(1)) begin
               k_we          = 1'b1;
               k_waddr       = cur_ff;
               k_wdata       = q_ff;
               state_in      = ST_IDLE;
               rsp_strobe_in = 1'b1;
               rsp_len_in    = wlen_ff;
               rsp_best_in   = best_ff;
               rsp_status_in = STATUS_DONE;
            end else begin
               // clone q
               cl_in    = count_ff + ST_W'(1);
               count_in = count_ff + ST_W'(1);
               l_we     = 1'b1;
               l_waddr  = count_ff + ST_W'(1);
               l_wdata  = plen_ff + ST_W'(1);
               k_raddr  = q_ff;
               state_in = ST_CL_LINK;
            end
         end
         ST_CL_LINK: begin
            k_we     = 1'b1;
            k_waddr  = cl_ff;
            k_wdata  = k_rd;
            state_in = ST_CUR_LINK;
         end
         ST_CUR_LINK: begin
            k_we     = 1'b1;
            k_waddr  = cur_ff;
            k_wdata  = cl_ff;
            state_in = ST_Q_LINK;
         end
         ST_Q_LINK: begin
            k_we     = 1'b1;
            k_waddr  = q_ff;
            k_wdata  = cl_ff;
            ci_in    = '0;
            cw_in    = 1'b0;
            state_in = ST_COPY;
         end
         ST_COPY: begin
            // read entry ci of row q, write the previous one into row cl
            t_raddr = {q_ff, ci_ff};
            if (cw_ff) begin
               t_we    = 1'b1;
               t_waddr = {cl_ff, cwi_ff};
               t_wdata = t_rd;
            end
            cwi_in = ci_ff;
            cw_in  = 1'b1;
            ci_in  = ci_ff + SYM_W'(1);
            if (ci_ff == ROW_LAST) begin
               state_in = ST_COPY_END;
            end
         end
         ST_COPY_END: begin
            t_we     = 1'b1;
            t_waddr  = {cl_ff, cwi_ff};
            t_wdata  = t_rd;
            cw_in    = 1'b0;
            state_in = ST_RED_RD;
         end
         ST_RED_RD: begin
            t_raddr  = {p_ff, sym_ff};
            k_raddr  = p_ff;
            state_in = ST_RED_CHK;
         end
         ST_RED_CHK: begin
            if (t_rd == q_ff) begin
               t_we    = 1'b1;
               t_waddr = {p_ff, sym_ff};
               t_wdata = cl_ff;
               p_in    = k_rd;
            end
            if (t_rd == q_ff && k_rd != NONE) begin
               state_in = ST_RED_RD;
            end else begin
               state_in      = ST_IDLE;
               rsp_strobe_in = 1'b1;
               rsp_len_in    = wlen_ff;
               rsp_best_in   = best_ff;
               rsp_status_in = STATUS_DONE;
            end
         end
         ST_M_RD: begin
            t_raddr  = {walk_ff, sym_ff};
            k_raddr  = walk_ff;
            state_in = ST_M_CHK;
         end
         ST_M_CHK: begin
            if (known && t_rd != NONE) begin
               walk_in       = t_rd;
               wlen_in       = m_len;
               best_in       = (m_len > best_ff) ? m_len : best_ff;
               state_in      = ST_IDLE;
               rsp_strobe_in = 1'b1;
               rsp_len_in    = m_len;
               rsp_best_in   = (m_len > best_ff) ? m_len : best_ff;
               rsp_status_in = STATUS_DONE;
            end else if (walk_ff == ROOT) begin
               best_in       = (wlen_ff > best_ff) ? wlen_ff : best_ff;
               state_in      = ST_IDLE;
               rsp_strobe_in = 1'b1;
               rsp_len_in    = wlen_ff;
               rsp_best_in   = (wlen_ff > best_ff) ? wlen_ff : best_ff;
               rsp_status_in = STATUS_DONE;
            end else begin
               // mismatch: fall back along the suffix link
               walk_in  = k_rd;
               l_raddr  = k_rd;
               state_in = ST_M_LEN;
            end
         end
         ST_M_LEN: begin
            wlen_in  = l_rd;
            state_in = ST_M_RD;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign busy             = (state_ff != ST_IDLE);
   assign rsp_strobe       = rsp_strobe_ff;
   assign rsp_match_length = LEN_OUT_W'(rsp_len_ff);
   assign rsp_best_length  = LEN_OUT_W'(rsp_best_ff);
   assign rsp_status       = rsp_status_ff;

   `SAM_ASSERT_IMP(a_count_bound, clock, reset, 1'b1, count_ff <= ST_W'(MAX_STATES - 1))
   `SAM_ASSERT_IMP(a_best_covers, clock, reset, !busy, best_ff >= wlen_ff)
   `SAM_ASSERT_IMP(a_last_alloc, clock, reset, !busy, last_ff <= count_ff)
   `SAM_ASSERT_NXT(a_match_busy, clock, reset, start && !busy && req_type == REQ_MATCH, busy)

endmodule

`default_nettype wire

// ===== rtl/core/sam_ram.sv =====
// generic single-write, single-read ram with registered read data
// no dependencies
`default_nettype none

module sam_ram #(
   parameter int WIDTH = 12,
   parameter int DEPTH = 4096
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] waddr,
   input  wire logic [WIDTH-1:0]         wdata,
   input  wire logic [$clog2(DEPTH)-1:0] raddr,
   output logic      [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata <= mem_ff[raddr];
   end

endmodule

`default_nettype wire

// ===== tb/sv/suffix_automaton_build_and_match_unit_tb.sv =====
// self-checking testbench for suffix_automaton_build_and_match_unit
// depends on sam_pkg and the unit rtl; holds its own automaton predictor
`timescale 1ns / 1ps
`default_nettype none

module suffix_automaton_build_and_match_unit_tb;
   import sam_pkg::*;

   localparam int NSTATES = DEF_MAX_STATES;
   localparam int NSYM    = DEF_ALPHABET;
   localparam int ROOT_ID = 1;
   localparam int WATCHDOG_CYCLES = 400000;

   typedef struct packed {
      logic             kind;
      logic [SYM_W-1:0] sym;
      logic             restart;
   } sam_beat_type;

   typedef struct packed {
      logic [LEN_OUT_W-1:0] cur_len;
      logic [LEN_OUT_W-1:0] best_len;
      logic                 status;
   } sam_answer_type;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 start = 1'b0;
   logic                 req_type = REQ_EXTEND;
   logic [SYM_W-1:0]     req_symbol = '0;
   logic                 req_start_query = 1'b0;
   logic                 busy;
   logic                 rsp_strobe;
   logic [LEN_OUT_W-1:0] rsp_match_length;
   logic [LEN_OUT_W-1:0] rsp_best_length;
   logic                 rsp_status;

   suffix_automaton_build_and_match_unit u_dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_type(req_type), .req_symbol(req_symbol), .req_start_query(req_start_query),
      .rsp_strobe(rsp_strobe), .rsp_match_length(rsp_match_length),
      .rsp_best_length(rsp_best_length), .rsp_status(rsp_status)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // shadow automaton
   logic [11:0] sa_next [0:NSTATES-1][0:NSYM-1];
   int unsigned sa_len  [0:NSTATES-1];
   int unsigned sa_link [0:NSTATES-1];
   int unsigned sa_last, sa_count, walk_node, walk_len, walk_best;

   sam_beat_type   pending_beats[$];
   sam_answer_type expected_answers[$];
   int             error_count = 0;
   int             quiet_cycles = 0;
   int             gap_left = 0;

   function automatic bit sa_append(int unsigned c);
      int unsigned p, cur, q, cl;
      if (c >= NSYM) return 1'b0;
      if (sa_count + 2 > NSTATES - 1) return 1'b0;
      p = sa_last;
      sa_count++;
      cur = sa_count;
      sa_len[cur] = sa_len[p] + 1;
      while (p != 0 && sa_next[p][c] == 0) begin
         sa_next[p][c] = cur[11:0];
         p = sa_link[p];
      end
      sa_last = cur;
      if (p == 0) begin
         sa_link[cur] = ROOT_ID;
         return 1'b1;
      end
      q = sa_next[p][c];
      if (sa_len[q] == sa_len[p] + 1) begin
         sa_link[cur] = q;
         return 1'b1;
      end
      sa_count++;
      cl = sa_count;
      sa_len[cl] = sa_len[p] + 1;
      for (int s = 0; s < NSYM; s++) sa_next[cl][s] = sa_next[q][s];
      sa_link[cl] = sa_link[q];
      sa_link[cur] = cl;
      sa_link[q] = cl;
      while (p != 0 && sa_next[p][c] == q[11:0]) begin
         sa_next[p][c] = cl[11:0];
         p = sa_link[p];
      end
      return 1'b1;
   endfunction

   function automatic void sa_walk(int unsigned c);
      bit known;
      int unsigned guard;
      known = c < NSYM;
      guard = 0;
      while (walk_node != ROOT_ID && guard < NSTATES &&
             (!known || sa_next[walk_node][c] == 0)) begin
         walk_node = sa_link[walk_node] % NSTATES;
         walk_len = sa_len[walk_node];
         guard++;
      end
      if (known && walk_node < NSTATES && sa_next[walk_node][c] != 0) begin
         walk_node = sa_next[walk_node][c];
         walk_len++;
      end
      if (walk_len > walk_best) walk_best = walk_len;
   endfunction

   function automatic sam_answer_type predict_answer(sam_beat_type b);
      sam_answer_type a;
      a.status = STATUS_DONE;
      if (b.restart) begin
         walk_node = ROOT_ID;
         walk_len = 0;
         walk_best = 0;
      end
      if (b.kind == REQ_EXTEND) begin
         if (!sa_append(b.sym)) a.status = STATUS_REFUSED;
      end else begin
         sa_walk(b.sym);
      end
      a.cur_len = walk_len[11:0];
      a.best_len = walk_best[11:0];
      return a;
   endfunction

   task automatic report_mismatch(string what, int got, int want);
      $display("mismatch %s: got %0d want %0d at %0t", what, got, want, $realtime);
      error_count++;
   endtask

   // stimulus generation
   logic [SYM_W-1:0] text_log[$];

   task automatic push_beat(logic kind, int sym, logic restart);
      sam_beat_type b;
      b.kind = kind;
      b.sym = sym[SYM_W-1:0];
      b.restart = restart;
      pending_beats = {pending_beats, b};
      if (kind == REQ_EXTEND && sym < NSYM) text_log = {text_log, sym[SYM_W-1:0]};
   endtask

   task automatic push_query(int span, bit mutate);
      int from, sym;
      from = $urandom_range(0, text_log.size() - 1);
      for (int i = 0; i < span; i++) begin
         sym = text_log[(from + i) % text_log.size()];
         if (mutate && $urandom_range(0, 5) == 0) sym = $urandom_range(0, 31);
         push_beat(REQ_MATCH, sym, i == 0);
      end
   endtask

   initial begin
      int sigma, run, total;
      // directed: extremes, out-of-alphabet symbols, restart on extend
      push_beat(REQ_MATCH, 0, 1'b0);
      push_beat(REQ_EXTEND, 31, 1'b0);
      push_beat(REQ_EXTEND, 26, 1'b1);
      push_beat(REQ_EXTEND, 0, 1'b0);
      push_beat(REQ_EXTEND, 25, 1'b0);
      push_beat(REQ_EXTEND, 0, 1'b0);
      push_beat(REQ_EXTEND, 0, 1'b0);
      push_beat(REQ_EXTEND, 25, 1'b0);
      push_beat(REQ_EXTEND, 0, 1'b0);
      push_beat(REQ_EXTEND, 0, 1'b0);
      push_beat(REQ_MATCH, 0, 1'b1);
      push_beat(REQ_MATCH, 0, 1'b0);
      push_beat(REQ_MATCH, 25, 1'b0);
      push_beat(REQ_MATCH, 0, 1'b0);
      push_beat(REQ_MATCH, 0, 1'b0);
      push_beat(REQ_MATCH, 31, 1'b0);
      push_beat(REQ_MATCH, 25, 1'b0);
      push_beat(REQ_EXTEND, 16, 1'b1);
      push_beat(REQ_MATCH, 15, 1'b0);
      push_beat(REQ_MATCH, 0, 1'b1);
      // random: mostly real substrings, some noise
      total = 0;
      while (total < 1100) begin
         case ($urandom_range(0, 9))
            0, 1, 2, 3: begin
               sigma = ($urandom_range(0, 1) != 0) ? 2 : NSYM;
               run = $urandom_range(1, 20);
               for (int i = 0; i < run; i++)
                  push_beat(REQ_EXTEND, $urandom_range(0, sigma - 1), 1'b0);
            end
            4, 5, 6, 7: begin
               run = $urandom_range(1, 30);
               push_query(run, 1'($urandom_range(0, 1)));
            end
            default: begin
               run = $urandom_range(1, 6);
               for (int i = 0; i < run; i++)
                  push_beat(1'($urandom_range(0, 1)), $urandom_range(0, 31),
                            $urandom_range(0, 3) == 0);
            end
         endcase
         total += run;
      end
      push_query(60, 1'b0);
      push_beat(REQ_EXTEND, 1, 1'b1);
      push_query(20, 1'b1);
   end

   // driver
   always @(posedge clock) begin
      sam_beat_type   b;
      sam_answer_type a;
      if (reset) begin
         start <= 1'b0;
      end else begin
         if (start && !busy) begin
            b.kind = req_type;
            b.sym = req_symbol;
            b.restart = req_start_query;
            a = predict_answer(b);
            expected_answers = {expected_answers, a};
         end
         if (start && busy) begin
            start <= 1'b1;
         end else if (gap_left > 0) begin
            gap_left <= gap_left - 1;
            start <= 1'b0;
         end else if (pending_beats.size() > 200 && $urandom_range(0, 7) == 0) begin
            gap_left <= $urandom_range(0, 16);
            start <= 1'b0;
         end else if (pending_beats.size() > 0) begin
            b = pending_beats.pop_front();
            req_type <= b.kind;
            req_symbol <= b.sym;
            req_start_query <= b.restart;
            start <= 1'b1;
         end else begin
            start <= 1'b0;
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      sam_answer_type want;
      if (!reset && rsp_strobe) begin
         if (expected_answers.size() == 0) begin
            report_mismatch("unexpected result, queued", 0, 0);
         end else begin
            want = expected_answers.pop_front();
            if (rsp_match_length !== want.cur_len)
               report_mismatch("match_length", rsp_match_length, want.cur_len);
            if (rsp_best_length !== want.best_len)
               report_mismatch("best_length", rsp_best_length, want.best_len);
            if (rsp_status !== want.status)
               report_mismatch("status", rsp_status, want.status);
         end
      end
   end

   // watchdog, long enough for the clearing sweep after reset
   always @(posedge clock) begin
      if ((start && !busy) || rsp_strobe) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_CYCLES) begin
         $display("FAIL");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      for (int s = 0; s < NSTATES; s++) begin
         for (int c = 0; c < NSYM; c++) sa_next[s][c] = '0;
         sa_len[s] = 0;
         sa_link[s] = 0;
      end
      sa_last = ROOT_ID;
      sa_count = 1;
      walk_node = ROOT_ID;
      walk_len = 0;
      walk_best = 0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      while (pending_beats.size() > 0 || start || expected_answers.size() > 0)
         @(posedge clock);
      repeat (50) @(posedge clock);
      if (error_count == 0 && expected_answers.size() == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule

`default_nettype wire

// ===== files.f =====
+incdir+rtl/core
rtl/core/sam_pkg.sv
rtl/core/sam_ram.sv
rtl/core/suffix_automaton_build_and_match_unit.sv
tb/sv/suffix_automaton_build_and_match_unit_tb.sv
